[rtl/assert_macros.svh]
// Assertion helpers used by bez_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/bez_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bez_pkg;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_POINT_T = 2'd0;
    localparam logic [1:0] OP_LENGTH  = 2'd1;
    localparam logic [1:0] OP_POINT_D = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_G1_X    = 3'd2;
    localparam logic [2:0] REG_G1_Y    = 3'd3;
    localparam logic [2:0] REG_G2_X    = 3'd4;
    localparam logic [2:0] REG_G2_Y    = 3'd5;
    localparam logic [2:0] REG_END_X   = 3'd6;
    localparam logic [2:0] REG_END_Y   = 3'd7;

    // Index of the last interpolation step of one de Casteljau evaluation.
    localparam logic [2:0] LERP_LAST = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       t_param;
        logic       t_div;
        logic       div_seg;
        logic       div_ip;
        logic       mul;
        logic       upd;
        logic [1:0] lerp_j;
        logic       sq;
        logic       sqrt_start;
        logic       advance;
        logic       res_cur;
        logic       res_end;
        logic       ip_mul;
        logic       ip_set;
        logic       ip_y;
        logic       out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       div_busy;
        logic       sqrt_busy;
        logic       last;
        logic       hit;
        logic       len_zero;
        logic       out_free;
    } sts_t;

    // Working slot written by interpolation step k of the evaluation.
    function automatic logic [1:0] lerp_idx(input logic [2:0] k);
        logic [1:0] j;
        unique case (k)
            3'd0:    j = 2'd0;
            3'd1:    j = 2'd1;
            3'd2:    j = 2'd2;
            3'd3:    j = 2'd0;
            3'd4:    j = 2'd1;
            default: j = 2'd0;
        endcase
        return j;
    endfunction

endpackage
`default_nettype wire

[rtl/cubic_bezier_arc_length_eval.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Ports           Contents
// s_        in   tdata[63:0]     item: param_t, distance, subdivisions
//                tuser[1:0]      operation
// m_        out  tdata[95:0]     item: point_x, point_y, arc_length
//                tuser[0:0]      past_end
// cfg_      in   wr_en/index     control point registers, no read-back
//
// One item at a time. A parameter query runs only the lerp steps. A length or
// distance query runs, per segment, the shared 64-step divider for the segment
// parameter, the lerp steps and the 33-step square root; a distance query then
// ends with the final interpolation.
// Reset is synchronous and active low; it clears the control points.
// A finished item waits in the output register while the next one is taken.
module cubic_bezier_arc_length_eval #(
    parameter int MAX_SUBDIV = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [16:0] param_t, [47:17] distance, [56:48] subdivisions, [63:57] zero
    input  logic [63:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] point_x, [63:32] point_y, [95:64] arc_length
    output logic [95:0] m_tdata,
    // [0] past_end
    output logic [0:0]  m_tuser
);
    import bez_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bez_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bez_dp #(
        .MAX_SUBDIV (MAX_SUBDIV)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );
endmodule
`default_nettype wire

[rtl/bez_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module bez_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);
    localparam logic [5:0] STEP_LAST = 6'd63;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] dvd_reg;
    logic [32:0] den_reg;
    logic [32:0] rem_reg;
    logic [33:0] trial;
    logic [33:0] diff;
    logic        ge;
    logic [32:0] rem_next;

    // One restoring step: bring down the next dividend bit.
    always_comb begin
        trial    = {rem_reg, dvd_reg[63]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[32:0] : trial[32:0];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Quotient bits shift in where dividend bits leave.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[62:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;
endmodule
`default_nettype wire

[rtl/bez_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module bez_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [64:0] radicand,
    output logic        busy,
    output logic [32:0] root
);
    localparam logic [5:0] STEP_LAST = 6'd32;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [65:0] rad_reg;
    logic [35:0] rem_reg;
    logic [32:0] root_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    // One digit pair per step, most significant first.
    always_comb begin
        rem_sh = {rem_reg[33:0], rad_reg[65:64]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and root registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= {1'b0, radicand};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[63:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[31:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

[rtl/bez_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module bez_dp #(
    parameter int MAX_SUBDIV = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wr_data,
    input  logic [63:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    input  bez_pkg::cmd_t cmd,
    output bez_pkg::sts_t sts,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,
    output logic [0:0]    m_tuser
);
    import bez_pkg::*;

    localparam int CW = $clog2(MAX_SUBDIV + 1);

    logic signed [31:0] cpx_reg [4];
    logic signed [31:0] cpy_reg [4];
    logic signed [31:0] wx_reg [4];
    logic signed [31:0] wy_reg [4];
    logic [1:0]         op_reg;
    logic [16:0]        tin_reg;
    logic [16:0]        t_reg;
    logic [30:0]        rem_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      i_reg;
    logic [31:0]        sum_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [50:0] prodx_reg;
    logic signed [50:0] prody_reg;
    logic [63:0]        sqx_reg;
    logic [63:0]        sqy_reg;
    logic [63:0]        ipnum_reg;
    logic signed [31:0] resx_reg;
    logic signed [31:0] resy_reg;
    logic               past_reg;
    logic               mvalid_reg;
    logic [95:0]        mdata_reg;
    logic               mpast_reg;

    logic [8:0]         n_in;
    logic [31:0]        n_wide;
    logic [16:0]        t_in;
    logic [1:0]         jp1;
    logic signed [32:0] dlx;
    logic signed [32:0] dly;
    logic signed [50:0] rndx;
    logic signed [50:0] rndy;
    logic signed [32:0] cdx;
    logic signed [32:0] cdy;
    logic [31:0]        magx;
    logic [31:0]        magy;
    logic [31:0]        ipm;
    logic [33:0]        sum_ext;
    logic               div_start;
    logic [63:0]        div_dvd;
    logic [32:0]        div_den;
    logic               div_busy;
    logic [63:0]        quot;
    logic               sqrt_busy;
    logic [32:0]        len;
    logic [31:0]        q32;

    // Input item decoding: clamp the segment count and the parameter.
    always_comb begin
        n_in = s_tdata[56:48];
        if (n_in == 9'd0) begin
            n_wide = 32'd1;
        end else if (32'(n_in) > 32'(MAX_SUBDIV)) begin
            n_wide = 32'(MAX_SUBDIV);
        end else begin
            n_wide = 32'(n_in);
        end
        t_in = (s_tdata[16] && (|s_tdata[15:0])) ? 17'h10000 : s_tdata[16:0];
    end

    // Lerp operands and rounding.
    always_comb begin
        jp1  = cmd.lerp_j + 2'd1;
        dlx  = {wx_reg[jp1][31], wx_reg[jp1]} - {wx_reg[cmd.lerp_j][31], wx_reg[cmd.lerp_j]};
        dly  = {wy_reg[jp1][31], wy_reg[jp1]} - {wy_reg[cmd.lerp_j][31], wy_reg[cmd.lerp_j]};
        rndx = prodx_reg + 51'sd32768;
        rndy = prody_reg + 51'sd32768;
    end

    // Chord vector from the previous point to the new curve point.
    always_comb begin
        cdx  = {wx_reg[0][31], wx_reg[0]} - {px_reg[31], px_reg};
        cdy  = {wy_reg[0][31], wy_reg[0]} - {py_reg[31], py_reg};
        magx = cdx[32] ? 32'(-cdx) : cdx[31:0];
        magy = cdy[32] ? 32'(-cdy) : cdy[31:0];
        ipm  = cmd.ip_y ? magy : magx;
        sum_ext = {2'b00, sum_reg} + {1'b0, len};
        q32  = quot[31:0];
    end

    // Shared divider: segment parameter or in-segment interpolation.
    always_comb begin
        div_start = cmd.div_seg | cmd.div_ip;
        if (cmd.div_seg) begin
            div_dvd = 64'({i_reg, 16'h0000}) + 64'(n_reg >> 1);
            div_den = 33'(n_reg);
        end else begin
            div_dvd = ipnum_reg;
            div_den = len;
        end
    end

    bez_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (quot)
    );

    bez_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (65'(sqx_reg) + 65'(sqy_reg)),
        .busy     (sqrt_busy),
        .root     (len)
    );

    // Control point registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                cpx_reg[k] <= '0;
                cpy_reg[k] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_START_X: cpx_reg[0] <= cfg_wr_data;
                REG_START_Y: cpy_reg[0] <= cfg_wr_data;
                REG_G1_X:    cpx_reg[1] <= cfg_wr_data;
                REG_G1_Y:    cpy_reg[1] <= cfg_wr_data;
                REG_G2_X:    cpx_reg[2] <= cfg_wr_data;
                REG_G2_Y:    cpy_reg[2] <= cfg_wr_data;
                REG_END_X:   cpx_reg[3] <= cfg_wr_data;
                REG_END_Y:   cpy_reg[3] <= cfg_wr_data;
                default:     cpx_reg[0] <= cpx_reg[0];
            endcase
        end
    end

    // Working datapath registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser;
            tin_reg  <= t_in;
            rem_reg  <= s_tdata[47:17];
            n_reg    <= n_wide[CW-1:0];
            i_reg    <= CW'(1);
            sum_reg  <= '0;
            px_reg   <= cpx_reg[0];
            py_reg   <= cpy_reg[0];
            past_reg <= 1'b0;
        end
        if (cmd.t_param || cmd.t_div) begin
            t_reg <= cmd.t_param ? tin_reg : quot[16:0];
            for (int k = 0; k < 4; k++) begin
                wx_reg[k] <= cpx_reg[k];
                wy_reg[k] <= cpy_reg[k];
            end
        end
        if (cmd.mul) begin
            prodx_reg <= dlx * $signed({1'b0, t_reg});
            prody_reg <= dly * $signed({1'b0, t_reg});
        end
        if (cmd.upd) begin
            wx_reg[cmd.lerp_j] <= wx_reg[cmd.lerp_j] + rndx[47:16];
            wy_reg[cmd.lerp_j] <= wy_reg[cmd.lerp_j] + rndy[47:16];
        end
        if (cmd.sq) begin
            sqx_reg <= magx * magx;
            sqy_reg <= magy * magy;
        end
        if (cmd.advance) begin
            sum_reg <= (|sum_ext[33:32]) ? 32'hFFFF_FFFF : sum_ext[31:0];
            rem_reg <= rem_reg - len[30:0];
            px_reg  <= wx_reg[0];
            py_reg  <= wy_reg[0];
            i_reg   <= i_reg + 1'b1;
        end
        if (cmd.res_cur) begin
            resx_reg <= wx_reg[0];
            resy_reg <= wy_reg[0];
        end
        if (cmd.res_end) begin
            resx_reg <= cpx_reg[3];
            resy_reg <= cpy_reg[3];
            past_reg <= 1'b1;
        end
        if (cmd.ip_mul) begin
            ipnum_reg <= (ipm * rem_reg) + 64'(len >> 1);
        end
        if (cmd.ip_set) begin
            if (cmd.ip_y) begin
                resy_reg <= cdy[32] ? (py_reg - q32) : (py_reg + q32);
            end else begin
                resx_reg <= cdx[32] ? (px_reg - q32) : (px_reg + q32);
            end
        end
    end

    // Output item register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            unique case (op_reg)
                OP_POINT_T: begin
                    mdata_reg <= {32'd0, resy_reg, resx_reg};
                    mpast_reg <= 1'b0;
                end
                OP_LENGTH: begin
                    mdata_reg <= {sum_reg, 64'd0};
                    mpast_reg <= 1'b0;
                end
                OP_POINT_D: begin
                    mdata_reg <= {32'd0, resy_reg, resx_reg};
                    mpast_reg <= past_reg;
                end
                default: begin
                    mdata_reg <= '0;
                    mpast_reg <= 1'b0;
                end
            endcase
        end
    end

    // Status toward the controller.
    always_comb begin
        sts.op        = op_reg;
        sts.div_busy  = div_busy;
        sts.sqrt_busy = sqrt_busy;
        sts.last      = (i_reg == n_reg);
        sts.hit       = (len >= 33'(rem_reg));
        sts.len_zero  = (len == 33'd0);
        sts.out_free  = !mvalid_reg || m_tready;
    end

    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = mdata_reg;
    assign m_tuser[0] = mpast_reg;
endmodule
`default_nettype wire

[rtl/bez_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bez_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output bez_pkg::cmd_t cmd,
    input  bez_pkg::sts_t sts
);
    import bez_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_TSET   = 13'b0000000000010,
        S_TWAIT  = 13'b0000000000100,
        S_MUL    = 13'b0000000001000,
        S_UPD    = 13'b0000000010000,
        S_SQ     = 13'b0000000100000,
        S_RGO    = 13'b0000001000000,
        S_RWAIT  = 13'b0000010000000,
        S_STEP   = 13'b0000100000000,
        S_IPMUL  = 13'b0001000000000,
        S_IPGO   = 13'b0010000000000,
        S_IPWAIT = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic       ipy_reg, ipy_next;

    // Sequencer for one item.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        ipy_next   = ipy_reg;
        cmd        = '0;
        cmd.lerp_j = lerp_idx(k_reg);
        cmd.ip_y   = ipy_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // No item is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = S_TSET;
                end
            end
            S_TSET: begin
                k_next   = '0;
                ipy_next = 1'b0;
                if (sts.op == OP_POINT_T) begin
                    cmd.t_param = 1'b1;
                    state_next  = S_MUL;
                end else if (sts.op == OP_NONE) begin
                    state_next = S_OUT;
                end else begin
                    cmd.div_seg = 1'b1;
                    state_next  = S_TWAIT;
                end
            end
            S_TWAIT: begin
                if (!sts.div_busy) begin
                    cmd.t_div  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                if (k_reg == LERP_LAST) begin
                    state_next = S_SQ;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_MUL;
                end
            end
            S_SQ: begin
                // The parameter query is done once the point is known.
                if (sts.op == OP_POINT_T) begin
                    cmd.res_cur = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    cmd.sq     = 1'b1;
                    state_next = S_RGO;
                end
            end
            S_RGO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_RWAIT;
            end
            S_RWAIT: begin
                if (!sts.sqrt_busy) begin
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                if (sts.op == OP_POINT_D && sts.hit) begin
                    if (sts.len_zero) begin
                        cmd.res_cur = 1'b1;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_IPMUL;
                    end
                end else begin
                    cmd.advance = 1'b1;
                    if (sts.last) begin
                        cmd.res_end = (sts.op == OP_POINT_D);
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_TSET;
                    end
                end
            end
            S_IPMUL: begin
                cmd.ip_mul = 1'b1;
                state_next = S_IPGO;
            end
            S_IPGO: begin
                cmd.div_ip = 1'b1;
                state_next = S_IPWAIT;
            end
            S_IPWAIT: begin
                if (!sts.div_busy) begin
                    cmd.ip_set = 1'b1;
                    if (ipy_reg) begin
                        state_next = S_OUT;
                    end else begin
                        ipy_next   = 1'b1;
                        state_next = S_IPMUL;
                    end
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            ipy_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ipy_reg   <= ipy_next;
        end
    end

    `ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready, state_reg == S_TSET)
    `ASSERT_IMPL(a_load_slot_free, aclk, aresetn, cmd.out_load, sts.out_free)
    `ASSERT_NEXT(a_div_runs, aclk, aresetn, cmd.div_seg || cmd.div_ip, sts.div_busy)
    `ASSERT_IMPL(a_step_root_ready, aclk, aresetn, state_reg == S_STEP, !sts.sqrt_busy)
endmodule
`default_nettype wire
